@@ rtl/clsr_pkg.sv @@
// clsr_pkg: constants, codes and controller/datapath interface types for the
// combined lcg shuffle generator. no dependencies.
package clsr_pkg;

    localparam int VAL_W           = 31;
    localparam int MUL_W           = 16;
    localparam int FOLD_W          = 8;
    localparam int TABLE_DEPTH_DEF = 32;
    localparam int WARMUP_STEPS    = 8;

    // moduli are 2^31 minus a small fold constant
    localparam logic [31:0]       MOD_A     = 32'd2147483563;
    localparam logic [31:0]       MOD_B     = 32'd2147483399;
    localparam logic [MUL_W-1:0]  MUL_A     = 16'd40014;
    localparam logic [MUL_W-1:0]  MUL_B     = 16'd40692;
    localparam logic [FOLD_W-1:0] FOLD_A    = 8'd85;
    localparam logic [FOLD_W-1:0] FOLD_B    = 8'd249;
    localparam logic [VAL_W-1:0]  SEED_RST  = 31'd36;
    localparam logic [VAL_W-1:0]  LCG_B_RST = 31'd123456789;

    typedef enum logic {
        GEN_A,
        GEN_B
    } gen_t;

    typedef enum logic [1:0] {
        SRC_INPUT,
        SRC_DEFAULT,
        SRC_ONE
    } seed_src_t;

    typedef struct packed {
        logic      load_seed;
        seed_src_t seed_src;
        logic      issue;
        gen_t      gen;
        logic      s1_from_res;
        logic      s2_from_res;
        logic      seed_wb;
        logic      slot_mul;
        logic      slot_fix;
        logic      tbl_rd;
        logic      finish;
    } clsr_cmd_t;

    typedef struct packed {
        logic s1_zero;
        logic cnt_zero;
    } clsr_status_t;

endpackage

@@ rtl/clsr_modmul.sv @@
// clsr_modmul: two-stage constant multiply and reduce, shared by both generators.
// depends on clsr_pkg.
module clsr_modmul (
    input  logic                        clk,
    input  logic                        issue,
    input  clsr_pkg::gen_t              gen,
    input  logic [clsr_pkg::VAL_W-1:0]  operand,
    output logic [clsr_pkg::VAL_W-1:0]  res
);
    import clsr_pkg::*;

    localparam int PROD_W = VAL_W + MUL_W;

    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W-1:0]   prod_next;
    gen_t                gen_reg;
    logic [MUL_W-1:0]    mul_sel;
    logic [FOLD_W-1:0]   fold_sel;
    logic [31:0]         mod_sel;
    logic [MUL_W-1:0]    hi;
    logic [MUL_W+FOLD_W-1:0] fold_prod;
    logic [31:0]         sum;

    assign mul_sel   = (gen == GEN_A) ? MUL_A : MUL_B;
    assign prod_next = PROD_W'(operand) * PROD_W'(mul_sel);

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            prod_reg <= prod_next;
            gen_reg  <= gen;
        end
    end

    // fold the bits above 2^31 back in, then one conditional subtract
    assign fold_sel  = (gen_reg == GEN_A) ? FOLD_A : FOLD_B;
    assign mod_sel   = (gen_reg == GEN_A) ? MOD_A : MOD_B;
    assign hi        = prod_reg[PROD_W-1:VAL_W];
    assign fold_prod = (MUL_W+FOLD_W)'(hi) * (MUL_W+FOLD_W)'(fold_sel);
    assign sum       = 32'(prod_reg[VAL_W-1:0]) + 32'(fold_prod);
    assign res       = (sum >= mod_sel) ? VAL_W'(sum - mod_sel) : VAL_W'(sum);

endmodule

@@ rtl/clsr_datapath.sv @@
// clsr_datapath: generator states, shuffle table, slot divider and output register.
// depends on clsr_pkg and clsr_modmul.
module clsr_datapath #(
    parameter int TABLE_DEPTH = clsr_pkg::TABLE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  clsr_pkg::clsr_cmd_t         cmd,
    output clsr_pkg::clsr_status_t      status,
    input  logic [clsr_pkg::VAL_W-1:0]  seed_value,
    input  logic                        cfg_we,
    input  logic [clsr_pkg::VAL_W-1:0]  cfg_data,
    output logic [clsr_pkg::VAL_W-1:0]  random_value
);
    import clsr_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + WARMUP_STEPS);
    localparam logic [CNT_W-1:0] CNT_START = CNT_W'(TABLE_DEPTH + WARMUP_STEPS - 1);

    // slot = last / SLOT_DIV by reciprocal multiply and one correction
    localparam longint unsigned SLOT_DIV   = 64'd1 + (64'(MOD_A) - 64'd1) / 64'(TABLE_DEPTH);
    localparam int              SLOT_SHIFT = 38;
    localparam longint unsigned SLOT_RECIP = (64'd1 << SLOT_SHIFT) / SLOT_DIV;
    localparam int RECIP_W = $clog2(SLOT_RECIP + 64'd1);
    localparam int SD_W    = $clog2(SLOT_DIV + 64'd1);
    localparam int SP_W    = VAL_W + RECIP_W;
    localparam int QE_W    = SP_W - SLOT_SHIFT;
    localparam int CHK_W   = QE_W + 1 + SD_W;

    logic [VAL_W-1:0] s1_reg, s1_next;
    logic [VAL_W-1:0] s2_reg, s2_next;
    logic [VAL_W-1:0] last_reg, last_next;
    logic [VAL_W-1:0] default_seed_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SP_W-1:0]  sprod_reg;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [VAL_W-1:0] rd_reg;
    logic [VAL_W-1:0] out_data_reg;
    logic [VAL_W-1:0] tbl [TABLE_DEPTH];

    logic [VAL_W-1:0] seed_raw, seed_mag;
    logic [VAL_W-1:0] mm_operand, mm_res;
    logic [QE_W-1:0]  q_est;
    logic [QE_W:0]    q_inc, q_fix;
    logic [CHK_W-1:0] chk;
    logic [VAL_W:0]   diff;
    logic [VAL_W-1:0] y_val;
    logic             tbl_we;
    logic [IDX_W-1:0] tbl_waddr;
    logic [VAL_W-1:0] tbl_wdata;

    assign mm_operand = (cmd.gen == GEN_A) ? s1_reg : s2_reg;

    clsr_modmul u_modmul (
        .clk     (clk),
        .issue   (cmd.issue),
        .gen     (cmd.gen),
        .operand (mm_operand),
        .res     (mm_res)
    );

    always_comb
    begin
        unique case (cmd.seed_src)
            SRC_INPUT:   seed_raw = seed_value;
            SRC_DEFAULT: seed_raw = default_seed_reg;
            default:     seed_raw = VAL_W'(1);
        endcase
        // zero seed is taken as one
        seed_mag = (seed_raw == '0) ? VAL_W'(1) : seed_raw;
    end

    assign q_est = sprod_reg[SP_W-1:SLOT_SHIFT];
    assign q_inc = {1'b0, q_est} + (QE_W+1)'(1);
    assign chk   = CHK_W'(q_inc) * CHK_W'(SLOT_DIV);
    assign q_fix = (CHK_W'(last_reg) >= chk) ? q_inc : {1'b0, q_est};
    assign slot_next = (q_fix >= (QE_W+1)'(TABLE_DEPTH)) ? IDX_W'(TABLE_DEPTH - 1)
                                                          : q_fix[IDX_W-1:0];

    // fold into 1..MOD_A-1
    assign diff  = {1'b0, rd_reg} - {1'b0, s2_reg};
    assign y_val = (diff[VAL_W] || (diff == '0)) ? VAL_W'(diff + (VAL_W+1)'(MOD_A - 32'd1))
                                                 : diff[VAL_W-1:0];

    always_comb
    begin
        s1_next   = s1_reg;
        s2_next   = s2_reg;
        last_next = last_reg;
        cnt_next  = cnt_reg;
        if (cmd.load_seed)
        begin
            s1_next  = seed_mag;
            s2_next  = seed_mag;
            cnt_next = CNT_START;
        end
        if (cmd.s1_from_res || cmd.seed_wb)
            s1_next = mm_res;
        if (cmd.s2_from_res)
            s2_next = mm_res;
        if (cmd.seed_wb)
        begin
            last_next = mm_res;
            cnt_next  = cnt_reg - CNT_W'(1);
        end
        if (cmd.finish)
            last_next = y_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg           <= '0;
            s2_reg           <= LCG_B_RST;
            last_reg         <= '0;
            cnt_reg          <= '0;
            default_seed_reg <= SEED_RST;
        end
        else
        begin
            s1_reg   <= s1_next;
            s2_reg   <= s2_next;
            last_reg <= last_next;
            cnt_reg  <= cnt_next;
            if (cfg_we)
                default_seed_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.slot_mul)
            sprod_reg <= SP_W'(last_reg) * SP_W'(SLOT_RECIP);
        if (cmd.slot_fix)
            slot_reg <= slot_next;
        if (cmd.finish)
            out_data_reg <= y_val;
    end

    // one write port: warm-up fill or slot refill
    assign tbl_we    = (cmd.seed_wb && (cnt_reg < CNT_W'(TABLE_DEPTH))) || cmd.finish;
    assign tbl_waddr = cmd.finish ? slot_reg : cnt_reg[IDX_W-1:0];
    assign tbl_wdata = cmd.finish ? s1_reg : mm_res;

    always_ff @(posedge clk)
    begin
        if (tbl_we)
            tbl[tbl_waddr] <= tbl_wdata;
        if (cmd.tbl_rd)
            rd_reg <= tbl[slot_reg];
    end

    assign status.s1_zero  = (s1_reg == '0);
    assign status.cnt_zero = (cnt_reg == '0);
    assign random_value    = out_data_reg;

endmodule

@@ rtl/clsr_ctrl.sv @@
// clsr_ctrl: sequencer for seeding warm-up and the four-step draw.
// depends on clsr_pkg.
module clsr_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    req_type,
    output logic                    out_valid,
    input  logic                    out_stall,
    output clsr_pkg::clsr_cmd_t     cmd,
    input  clsr_pkg::clsr_status_t  status
);
    import clsr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_MUL,
        ST_SEED_WB,
        ST_DRAW0,
        ST_DRAW1,
        ST_DRAW2,
        ST_DRAW3
    } state_t;

    state_t state_reg, state_next;
    logic   seeded_reg, seeded_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        seeded_next    = seeded_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type || !seeded_reg || status.s1_zero)
                    begin
                        cmd.load_seed = 1'b1;
                        if (req_type)
                            cmd.seed_src = SRC_INPUT;
                        else if (!seeded_reg)
                            cmd.seed_src = SRC_DEFAULT;
                        else
                            cmd.seed_src = SRC_ONE;
                        state_next = ST_SEED_MUL;
                    end
                    else
                    begin
                        // first draw step overlaps the accept cycle
                        cmd.issue    = 1'b1;
                        cmd.gen      = GEN_A;
                        cmd.slot_mul = 1'b1;
                        state_next   = ST_DRAW1;
                    end
                end
            end
            ST_SEED_MUL:
            begin
                cmd.issue  = 1'b1;
                cmd.gen    = GEN_A;
                state_next = ST_SEED_WB;
            end
            ST_SEED_WB:
            begin
                cmd.seed_wb = 1'b1;
                cmd.gen     = GEN_A;
                if (status.cnt_zero)
                begin
                    seeded_next = 1'b1;
                    state_next  = ST_DRAW0;
                end
                else
                    state_next = ST_SEED_MUL;
            end
            ST_DRAW0:
            begin
                cmd.issue    = 1'b1;
                cmd.gen      = GEN_A;
                cmd.slot_mul = 1'b1;
                state_next   = ST_DRAW1;
            end
            ST_DRAW1:
            begin
                cmd.s1_from_res = 1'b1;
                cmd.issue       = 1'b1;
                cmd.gen         = GEN_B;
                cmd.slot_fix    = 1'b1;
                state_next      = ST_DRAW2;
            end
            ST_DRAW2:
            begin
                cmd.s2_from_res = 1'b1;
                cmd.gen         = GEN_B;
                cmd.tbl_rd      = 1'b1;
                state_next      = ST_DRAW3;
            end
            ST_DRAW3:
            begin
                if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seeded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seeded_reg    <= seeded_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ rtl/combined_lcg_shuffle_rng.sv @@
// combined_lcg_shuffle_rng: top level of the combined lcg generator with shuffle table.
// depends on clsr_pkg, clsr_ctrl, clsr_datapath (and clsr_modmul below it).
//
// usage
//  - input channel (in_valid / in_stall): one request per transfer; req_type 0 asks
//    for the next number, 1 reseeds with seed_value (zero taken as one), then draws
//  - output channel (out_valid / out_stall): one random_value per request, 1..2^31-86
//  - config channel (cfg_valid / cfg_ready / cfg_data): writes default_seed, always
//    ready; write it only while no request is in flight
//  - a plain draw starts in the accept cycle and ends in the last draw state, which
//    registers the result; no request is taken meanwhile; steps follow the shared
//    two-stage modular multiplier (one generator per cycle) and registered table read
//  - a reseed, or the first draw after reset, first runs a warm-up: the first
//    generator steps TABLE_DEPTH+8 times, a multiply and a write-back state each
//  - while a result waits under out_stall the next request is still taken; its
//    result holds in the last draw step until the output register empties
//  - reset clears the seeded flag and out_valid; random_value and the shuffle table
//    are not cleared, every slot is filled by the warm-up before it is read
module combined_lcg_shuffle_rng #(
    parameter int TABLE_DEPTH = clsr_pkg::TABLE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        req_type,
    input  logic [clsr_pkg::VAL_W-1:0]  seed_value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [clsr_pkg::VAL_W-1:0]  random_value,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [clsr_pkg::VAL_W-1:0]  cfg_data
);
    import clsr_pkg::*;

    clsr_cmd_t    cmd;
    clsr_status_t status;

    // config register takes a transfer in any cycle
    assign cfg_ready = 1'b1;

    clsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    clsr_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .seed_value   (seed_value),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .random_value (random_value)
    );

    // a request in flight blocks the next one
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while a request is in flight");

    // a result is never written over one that still waits
    a_finish_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid || !out_stall))
        else $error("result finished while output register is stalled");

    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid)
        else $error("finished result not presented");

    // seeding starts only on an input transfer
    a_seed_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_seed |-> (in_valid && !in_stall))
        else $error("seed load without an input transfer");

endmodule
